// ===== rtl/xyscope_pkg.sv =====
// shared types, constants and helpers of the stereo xy scope
package xyscope_pkg;

  // coordinate and fixed-point format
  localparam int COORD_BITS  = 12;
  localparam int SIZE_BITS   = COORD_BITS + 1;
  localparam int FRAC_BITS   = 14;
  localparam int SAMPLE_BITS = 16;
  localparam int MAP_SHIFT   = 16;

  // filter arithmetic widths
  localparam int STATE_BITS = 32;
  localparam int BAND_BITS  = STATE_BITS + 1;
  localparam int SUM_BITS   = STATE_BITS + 4;
  localparam int COEF_BITS  = 16;
  localparam int PROD_BITS  = STATE_BITS + COEF_BITS;
  localparam int COEF_SHIFT = 15;

  // q15 cutoff coefficients, about 0.15 and 0.45
  localparam logic signed [COEF_BITS-1:0] COEF_LOW  = 16'sd4915;
  localparam logic signed [COEF_BITS-1:0] COEF_HIGH = 16'sd14746;

  // frame size limits and reset values
  localparam logic [SIZE_BITS-1:0] SIZE_MIN   = SIZE_BITS'(2);
  localparam logic [SIZE_BITS-1:0] SIZE_MAX   = SIZE_BITS'(1 << COORD_BITS);
  localparam logic [SIZE_BITS-1:0] RST_WIDTH  = SIZE_BITS'(320);
  localparam logic [SIZE_BITS-1:0] RST_HEIGHT = SIZE_BITS'(200);

  // register indexes of the configuration port
  localparam int CFG_ADDR_BITS = 2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_STYLE  = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_HEIGHT = 2'd2;

  // output color codes
  localparam logic [1:0] COLOR_WHITE = 2'd0;
  localparam logic [1:0] COLOR_RED   = 2'd1;
  localparam logic [1:0] COLOR_GREEN = 2'd2;
  localparam logic [1:0] COLOR_BLUE  = 2'd3;

  typedef enum logic [1:0] {
    DRAW_DOTS   = 2'd0,
    DRAW_LINES  = 2'd1,
    DRAW_CDOTS  = 2'd2,
    DRAW_CLINES = 2'd3
  } style_t;

  // one classified sample pair waiting in the queue
  typedef struct packed {
    style_t                        style;
    logic                          start;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic [SIZE_BITS-1:0]          width;
    logic [SIZE_BITS-1:0]          height;
  } item_t;

  // band outputs of one filter lane
  typedef struct packed {
    logic signed [STATE_BITS-1:0] low;
    logic signed [STATE_BITS-1:0] mid;
    logic signed [BAND_BITS-1:0]  high;
  } band_t;

  // request to a coordinate mapper
  typedef struct packed {
    logic                  go;
    logic                  wide;
    logic [SIZE_BITS-1:0]  scale;
    logic [COORD_BITS-1:0] offset;
    logic [COORD_BITS-1:0] hi;
  } map_req_t;

  // saturate a wide sum to the signed state range
  function automatic logic signed [STATE_BITS-1:0] sat32(input logic signed [SUM_BITS-1:0] v);
    if (v[SUM_BITS-1:STATE_BITS-1] == {(SUM_BITS-STATE_BITS+1){1'b0}} ||
        v[SUM_BITS-1:STATE_BITS-1] == {(SUM_BITS-STATE_BITS+1){1'b1}}) begin
      return v[STATE_BITS-1:0];
    end else if (v[SUM_BITS-1]) begin
      return {1'b1, {(STATE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_BITS-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/xyscope_front.sv =====
// front end: configuration registers, input beat acceptance and classification
module xyscope_front
  import xyscope_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [SIZE_BITS-1:0]     cfg_wdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [31:0]              in_tdata,
  input  logic [0:0]               in_tuser,
  input  logic                     q_full,
  output logic                     q_push,
  output item_t                    q_item
);

  style_t               style_r;
  logic [SIZE_BITS-1:0] width_r;
  logic [SIZE_BITS-1:0] height_r;

  // clamp a frame size to the supported range
  function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] r);
    if (r < SIZE_MIN) begin
      return SIZE_MIN;
    end else if (r > SIZE_MAX) begin
      return SIZE_MAX;
    end else begin
      return r;
    end
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      style_r  <= DRAW_DOTS;
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_STYLE:  style_r  <= style_t'(cfg_wdata[1:0]);
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // accept a beat whenever the queue has room
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // tag the beat with style and effective frame size
  always_comb begin
    q_item.style  = style_r;
    q_item.start  = in_tuser[0];
    q_item.left   = in_tdata[15:0];
    q_item.right  = in_tdata[31:16];
    q_item.width  = eff_size(width_r);
    q_item.height = eff_size(height_r);
  end

endmodule

// ===== rtl/xyscope_fifo.sv =====
// short queue of classified items between front and back
module xyscope_fifo
  import xyscope_pkg::*;
#(
  parameter int DEPTH = 2
)(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !valid))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
      (push && !pop && count_r == CW'(DEPTH - 1)) |=> full)
    else $error("queue count lost an entry");

endmodule

// ===== rtl/xyscope_svf.sv =====
// one channel of two cascaded state-variable filters sharing one multiplier
module xyscope_svf
  import xyscope_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          done,
  output band_t                         bands
);

  localparam int STEP_BITS = 4;
  localparam logic [STEP_BITS-1:0] ST_H1 = 4'd0;
  localparam logic [STEP_BITS-1:0] ST_P1 = 4'd1;
  localparam logic [STEP_BITS-1:0] ST_M1 = 4'd2;
  localparam logic [STEP_BITS-1:0] ST_P2 = 4'd3;
  localparam logic [STEP_BITS-1:0] ST_L1 = 4'd4;
  localparam logic [STEP_BITS-1:0] ST_P3 = 4'd5;
  localparam logic [STEP_BITS-1:0] ST_M2 = 4'd6;
  localparam logic [STEP_BITS-1:0] ST_P4 = 4'd7;
  localparam logic [STEP_BITS-1:0] ST_L2 = 4'd8;

  logic signed [STATE_BITS-1:0] m1_r, l1_r, m2_r, l2_r;
  logic signed [STATE_BITS-1:0] h1_r, h2_r;
  logic signed [PROD_BITS-1:0]  p_r;
  logic [STEP_BITS-1:0]         step_r;
  logic                         busy_r;
  logic                         done_r;

  logic signed [SUM_BITS-1:0]   in_ext;
  logic signed [SUM_BITS-1:0]   h1_sum;
  logic signed [SUM_BITS-1:0]   h2_sum;
  logic signed [STATE_BITS-1:0] mul_a;
  logic signed [COEF_BITS-1:0]  mul_c;
  logic signed [PROD_BITS-1:0]  p_nxt;
  logic signed [PROD_BITS-1:0]  p_scaled;
  logic signed [STATE_BITS-1:0] acc_old;
  logic signed [SUM_BITS-1:0]   acc_sum;
  logic signed [STATE_BITS-1:0] acc_new;

  // high-pass terms of both stages
  assign in_ext = {{(SUM_BITS-SAMPLE_BITS-FRAC_BITS){sample[SAMPLE_BITS-1]}}, sample,
                   {FRAC_BITS{1'b0}}};
  assign h1_sum = in_ext - (SUM_BITS'(m1_r) <<< 1) - SUM_BITS'(l1_r);
  assign h2_sum = SUM_BITS'(m1_r) + SUM_BITS'(h1_r) - (SUM_BITS'(m2_r) <<< 1)
                - SUM_BITS'(l2_r);

  // shared coefficient multiplier
  always_comb begin
    mul_a = m2_r;
    mul_c = COEF_HIGH;
    case (step_r)
      ST_P1: begin mul_a = h1_r; mul_c = COEF_LOW;  end
      ST_P2: begin mul_a = m1_r; mul_c = COEF_LOW;  end
      ST_P3: begin mul_a = h2_r; mul_c = COEF_HIGH; end
      default: ;
    endcase
  end
  assign p_nxt = PROD_BITS'(mul_a) * PROD_BITS'(mul_c);

  // integrator update with floored product
  assign p_scaled = p_r >>> COEF_SHIFT;
  always_comb begin
    case (step_r)
      ST_M1:   acc_old = m1_r;
      ST_L1:   acc_old = l1_r;
      ST_M2:   acc_old = m2_r;
      default: acc_old = l2_r;
    endcase
  end
  assign acc_sum = SUM_BITS'(acc_old) + SUM_BITS'(p_scaled);
  assign acc_new = sat32(acc_sum);

  // step sequencer and persistent integrators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
      m1_r   <= '0;
      l1_r   <= '0;
      m2_r   <= '0;
      l2_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= ST_H1;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        unique case (step_r) inside
          ST_M1: m1_r <= acc_new;
          ST_L1: l1_r <= acc_new;
          ST_M2: m2_r <= acc_new;
          ST_L2: begin
            l2_r   <= acc_new;
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // working values
  always_ff @(posedge clk) begin
    if (busy_r && !start) begin
      case (step_r) inside
        ST_H1:                      h1_r <= sat32(h1_sum);
        ST_L1:                      h2_r <= sat32(h2_sum);
        ST_P1, ST_P2, ST_P3, ST_P4: p_r  <= p_nxt;
        default: ;
      endcase
    end
  end

  assign done       = done_r;
  assign bands.low  = l1_r;
  assign bands.mid  = l2_r;
  assign bands.high = BAND_BITS'(m2_r) + BAND_BITS'(h2_r);

endmodule

// ===== rtl/xyscope_map.sv =====
// two-stage coordinate mapper: scale multiply, then floor shift, offset and clamp
module xyscope_map
  import xyscope_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  map_req_t                    req,
  input  logic signed [BAND_BITS-1:0] value,
  output logic                        ready,
  output logic [COORD_BITS-1:0]       coord
);

  localparam int MP_BITS = BAND_BITS + SIZE_BITS + 1;
  // holds the shifted product plus offset with margin
  localparam int R_BITS  = COORD_BITS + 6;

  logic signed [MP_BITS-1:0]  prod_r;
  logic                       wide_r;
  logic [COORD_BITS-1:0]      off_r;
  logic [COORD_BITS-1:0]      hi_r;
  logic                       v1_r;
  logic                       ready_r;
  logic [COORD_BITS-1:0]      coord_r;

  logic signed [SIZE_BITS:0]  scale_s;
  logic signed [MP_BITS-1:0]  q_full;
  logic signed [R_BITS-1:0]   q_s;
  logic signed [R_BITS-1:0]   off_s;
  logic signed [R_BITS-1:0]   hi_s;
  logic signed [R_BITS-1:0]   r_s;

  // stage one: product of value and scale
  assign scale_s = $signed({1'b0, req.scale});
  always_ff @(posedge clk) begin
    if (req.go) begin
      prod_r <= MP_BITS'(value) * MP_BITS'(scale_s);
      wide_r <= req.wide;
      off_r  <= req.offset;
      hi_r   <= req.hi;
    end
  end

  // stage two: floor shift, add offset, clamp
  assign q_full = wide_r ? (prod_r >>> (FRAC_BITS + MAP_SHIFT)) : (prod_r >>> MAP_SHIFT);
  assign q_s    = R_BITS'(q_full);
  assign off_s  = $signed({{(R_BITS-COORD_BITS){1'b0}}, off_r});
  assign hi_s   = $signed({{(R_BITS-COORD_BITS){1'b0}}, hi_r});
  assign r_s    = q_s + off_s;

  always_ff @(posedge clk) begin
    if (v1_r) begin
      if (r_s[R_BITS-1]) begin
        coord_r <= '0;
      end else if (r_s > hi_s) begin
        coord_r <= hi_r;
      end else begin
        coord_r <= r_s[COORD_BITS-1:0];
      end
    end
  end

  // result flag stays up until the next request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      ready_r <= 1'b0;
    end else begin
      v1_r <= req.go;
      if (req.go) begin
        ready_r <= 1'b0;
      end else if (v1_r) begin
        ready_r <= 1'b1;
      end
    end
  end

  assign ready = ready_r;
  assign coord = coord_r;

endmodule

// ===== rtl/xyscope_back.sv =====
// back end: band filters, coordinate mapping, previous points and output register
module xyscope_back
  import xyscope_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_FILT  = 5'b00100,
    S_ISSUE = 5'b01000,
    S_MAP   = 5'b10000
  } state_t;

  localparam logic [1:0] BAND_LOW  = 2'd0;
  localparam logic [1:0] BAND_MID  = 2'd1;
  localparam logic [1:0] BAND_HIGH = 2'd2;
  localparam int NUM_BANDS = 3;

  state_t                state_r, state_nxt;
  item_t                 item_r;
  logic [1:0]            band_r;
  logic [COORD_BITS-1:0] prev_x_r [NUM_BANDS];
  logic [COORD_BITS-1:0] prev_y_r [NUM_BANDS];

  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_xs_r, out_ys_r, out_xe_r, out_ye_r;
  logic [1:0]            out_color_r;
  logic                  out_seg_r;
  logic                  out_last_r;

  logic colour, lines, mono_lines;
  logic emit, band_last, out_free;
  logic lane_start, out_load, prev_we, band_inc;
  logic lane_done_l, lane_done_r;
  band_t band_l, band_r_ch;
  logic map_ready_x, map_ready_y;
  logic [COORD_BITS-1:0] coord_x, coord_y;
  map_req_t req_x, req_y;
  logic signed [BAND_BITS-1:0] val_x, val_y;
  logic [SIZE_BITS-1:0] scale_x, scale_y;
  logic [1:0] color_nxt;

  // style decode of the current item
  assign colour     = (item_r.style == DRAW_CDOTS) || (item_r.style == DRAW_CLINES);
  assign lines      = (item_r.style == DRAW_LINES) || (item_r.style == DRAW_CLINES);
  assign mono_lines = (item_r.style == DRAW_LINES);
  assign emit       = !lines || !item_r.start;
  assign band_last  = !colour || (band_r == BAND_HIGH);
  assign out_free   = !out_valid_r || out_tready;

  // filter lanes, left and right run in step
  xyscope_svf u_svf_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lane_start),
    .sample (item_r.left),
    .done   (lane_done_l),
    .bands  (band_l)
  );

  xyscope_svf u_svf_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lane_start),
    .sample (item_r.right),
    .done   (lane_done_r),
    .bands  (band_r_ch)
  );

  // mapper operands for the current band
  always_comb begin
    if (!colour) begin
      val_x = {{(BAND_BITS-SAMPLE_BITS){item_r.left[SAMPLE_BITS-1]}}, item_r.left};
      val_y = {{(BAND_BITS-SAMPLE_BITS){item_r.right[SAMPLE_BITS-1]}}, item_r.right};
    end else begin
      case (band_r)
        BAND_LOW: begin
          val_x = BAND_BITS'(band_l.low);
          val_y = BAND_BITS'(band_r_ch.low);
        end
        BAND_MID: begin
          val_x = BAND_BITS'(band_l.mid);
          val_y = BAND_BITS'(band_r_ch.mid);
        end
        default: begin
          val_x = band_l.high;
          val_y = band_r_ch.high;
        end
      endcase
    end
  end

  // scale, offset and clamp limit per style
  assign scale_x = mono_lines ? item_r.width - 1'b1 : item_r.width;
  assign scale_y = mono_lines ? item_r.height - 1'b1 : item_r.height;

  always_comb begin
    req_x.go     = (state_r == S_ISSUE);
    req_x.wide   = colour;
    req_x.scale  = scale_x;
    req_x.offset = COORD_BITS'(scale_x >> 1);
    req_x.hi     = colour ? COORD_BITS'(item_r.width - SIZE_BITS'(2))
                          : COORD_BITS'(item_r.width - SIZE_BITS'(1));
    req_y.go     = (state_r == S_ISSUE);
    req_y.wide   = colour;
    req_y.scale  = scale_y;
    req_y.offset = COORD_BITS'(scale_y >> 1);
    req_y.hi     = colour ? COORD_BITS'(item_r.height - SIZE_BITS'(2))
                          : COORD_BITS'(item_r.height - SIZE_BITS'(1));
  end

  xyscope_map u_map_x (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_x),
    .value (val_x),
    .ready (map_ready_x),
    .coord (coord_x)
  );

  xyscope_map u_map_y (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_y),
    .value (val_y),
    .ready (map_ready_y),
    .coord (coord_y)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    q_pop      = 1'b0;
    lane_start = 1'b0;
    out_load   = 1'b0;
    prev_we    = 1'b0;
    band_inc   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (colour) begin
          lane_start = 1'b1;
          state_nxt  = S_FILT;
        end else begin
          state_nxt = S_ISSUE;
        end
      end
      S_FILT: begin
        if (lane_done_l) begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        state_nxt = S_MAP;
      end
      S_MAP: begin
        if (map_ready_x && (!emit || out_free)) begin
          out_load = emit;
          prev_we  = lines;
          if (band_last) begin
            state_nxt = S_IDLE;
          end else begin
            band_inc  = 1'b1;
            state_nxt = S_ISSUE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // band color
  always_comb begin
    case (band_r)
      BAND_LOW: color_nxt = COLOR_RED;
      BAND_MID: color_nxt = COLOR_GREEN;
      default:  color_nxt = COLOR_BLUE;
    endcase
    if (!colour) begin
      color_nxt = COLOR_WHITE;
    end
  end

  // control registers and previous points
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      band_r      <= BAND_LOW;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BANDS; i++) begin
        prev_x_r[i] <= '0;
        prev_y_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        band_r <= BAND_LOW;
      end else if (band_inc) begin
        band_r <= band_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (prev_we) begin
        prev_x_r[band_r] <= coord_x;
        prev_y_r[band_r] <= coord_y;
      end
    end
  end

  // item and output beat payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    if (out_load) begin
      out_xs_r    <= lines ? prev_x_r[band_r] : coord_x;
      out_ys_r    <= lines ? prev_y_r[band_r] : coord_y;
      out_xe_r    <= coord_x;
      out_ye_r    <= coord_y;
      out_color_r <= color_nxt;
      out_seg_r   <= lines;
      out_last_r  <= band_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ye_r, out_xe_r, out_ys_r, out_xs_r};
  assign out_tuser  = {out_seg_r, out_color_r};
  assign out_tlast  = out_last_r;

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
      lane_done_l == lane_done_r)
    else $error("left and right filter lanes out of step");
  a_mappers_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
      map_ready_x == map_ready_y)
    else $error("x and y mappers out of step");
  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
      (out_load && band_last) |=> (state_r == S_IDLE))
    else $error("last beat of a sample pair did not end the item");

endmodule

// ===== rtl/stereo_xy_scope_band_split.sv =====
// top level of the stereo xy scope with band split
// flow: in the white styles a sample pair is mapped once; in the colour styles both filter
// lanes run first, then the red, green and blue beats follow one band after another
// the back-end sequencer takes a new sample pair only when it is through with the last one and
// stalls while results do not drain; a 2-entry queue lets the input run ahead
// reset (rst_n low, synchronous): style dots, frame 320 x 200, filter state and previous
// points cleared, queue and output register empty
module stereo_xy_scope_band_split
  import xyscope_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
)(
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration write port
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [SIZE_BITS-1:0]     cfg_wdata,
  // input sample pairs
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [31:0]              in_tdata,  // left_sample, right_sample
  input  logic [0:0]               in_tuser,  // starts_buffer
  // result beats
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [47:0]              out_tdata, // x_start, y_start, x_end, y_end
  output logic [2:0]               out_tuser, // color_code, is_segment
  output logic                     out_tlast  // last_of_run
);

  logic  q_full, q_push, q_pop, q_valid;
  item_t q_in, q_head;

  xyscope_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  xyscope_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  xyscope_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
